[rtl/lru_key_value_cache_assert.svh]
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// same-cycle and next-cycle implication checks on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared constants for the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int              CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

[rtl/lkvc_ram.sv]
// ----------------------------------------------------------------------------
// lkvc_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ram
  import lkvc_pkg::*;
#(
  parameter int WIDTH = KEY_BITS_DEF,
  parameter int DEPTH = ENTRIES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store kept in least-recently-used order
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Keys and values sit
// in one ram and recency ranks in a second ram, each with one read port, so
// every request is handled by a sweep over all ENTRIES slots: a scan pass
// reads key, value and rank of each slot to find the hit, the least recent
// slot and the lowest free slot, then an update pass rewrites the ranks one
// slot a cycle. A get miss finishes after the scan pass; every other request
// also runs the update pass. The result shows on hit_o, read_value_o and
// evicted_o for the single cycle in which done_o is high, and busy is already
// low in that cycle. The receiver cannot stall, so the result must be
// captured then. No clearing pass runs after reset; slot valid bits live in
// flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cmd_i,
  input  wire logic [KEY_BITS-1:0]   lookup_key_i,
  input  wire logic [VALUE_BITS-1:0] write_value_i,
  input  wire logic                  capacity_we_i,
  input  wire logic [CAP_BITS-1:0]   capacity_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic [VALUE_BITS-1:0]      read_value_o,
  output logic                       evicted_o
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;
  localparam int EW   = KEY_BITS + VALUE_BITS;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_UPDATE,
    S_UPD_END
  } state_e;

  state_e state_q, state_d;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  hit_q, hit_d;
  logic [VALUE_BITS-1:0] rdval_q, rdval_d;
  logic                  evict_q, evict_d;

  logic [CAP_BITS-1:0]   cap_q;
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [CW-1:0]         count_q, count_d;

  logic                  cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;

  logic [IW-1:0]         ptr_q, ptr_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [IW-1:0]         chk_idx_q, chk_idx_d;

  // scan trackers
  logic                  found_q, found_d;
  logic [IW-1:0]         m_slot_q, m_slot_d;
  logic [IW-1:0]         m_rank_q, m_rank_d;
  logic [VALUE_BITS-1:0] m_val_q, m_val_d;
  logic                  lru_any_q, lru_any_d;
  logic [IW-1:0]         lru_slot_q, lru_slot_d;
  logic [IW-1:0]         lru_rank_q, lru_rank_d;
  logic                  free_any_q, free_any_d;
  logic [IW-1:0]         free_slot_q, free_slot_d;

  // update pass control
  logic [IW-1:0]         tgt_q, tgt_d;
  logic [IW-1:0]         thr_q, thr_d;
  logic                  age_all_q, age_all_d;

  logic                  ent_we;
  logic [IW-1:0]         ent_waddr;
  logic [EW-1:0]         ent_wdata;
  logic [EW-1:0]         ent_rdata;
  logic                  rank_we;
  logic [IW-1:0]         rank_waddr;
  logic [IW-1:0]         rank_wdata;
  logic [IW-1:0]         rank_rdata;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  rd_valid;
  logic [CMPW-1:0]       eff_cap;
  logic                  full;
  logic                  last;

  assign rd_key   = ent_rdata[EW-1 -: KEY_BITS];
  assign rd_val   = ent_rdata[VALUE_BITS-1:0];
  assign rd_valid = valid_q[chk_idx_q];
  assign last     = (ptr_q == IW'(ENTRIES - 1));

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMPW'(1);
    end else if (CMPW'(cap_q) > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = CMPW'(cap_q);
    end
  end

  assign full = (CMPW'(count_q) >= eff_cap);

  lkvc_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ent_rdata)
  );

  lkvc_ram #(
    .WIDTH (IW),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (rank_wdata),
    .raddr_i (ptr_q),
    .rdata_o (rank_rdata)
  );

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    done_d      = 1'b0;
    hit_d       = hit_q;
    rdval_d     = rdval_q;
    evict_d     = evict_q;
    valid_d     = valid_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = ptr_q;
    found_d     = found_q;
    m_slot_d    = m_slot_q;
    m_rank_d    = m_rank_q;
    m_val_d     = m_val_q;
    lru_any_d   = lru_any_q;
    lru_slot_d  = lru_slot_q;
    lru_rank_d  = lru_rank_q;
    free_any_d  = free_any_q;
    free_slot_d = free_slot_q;
    tgt_d       = tgt_q;
    thr_d       = thr_q;
    age_all_d   = age_all_q;
    ent_we      = 1'b0;
    ent_waddr   = tgt_q;
    ent_wdata   = {key_q, val_q};
    rank_we     = 1'b0;
    rank_waddr  = chk_idx_q;
    rank_wdata  = '0;

    // slot data returned from the read issued last cycle
    if ((state_q == S_SCAN || state_q == S_SCAN_END) && chk_vld_q) begin
      if (rd_valid && rd_key == key_q && !found_q) begin
        found_d  = 1'b1;
        m_slot_d = chk_idx_q;
        m_rank_d = rank_rdata;
        m_val_d  = rd_val;
      end
      if (rd_valid && (!lru_any_q || rank_rdata > lru_rank_q)) begin
        lru_any_d  = 1'b1;
        lru_slot_d = chk_idx_q;
        lru_rank_d = rank_rdata;
      end
      if (!rd_valid && !free_any_q) begin
        free_any_d  = 1'b1;
        free_slot_d = chk_idx_q;
      end
    end

    if ((state_q == S_UPDATE || state_q == S_UPD_END) && chk_vld_q) begin
      if (chk_idx_q == tgt_q) begin
        rank_we    = 1'b1;
        rank_wdata = '0;
      end else if (rd_valid && (age_all_q || rank_rdata < thr_q)) begin
        rank_we    = 1'b1;
        rank_wdata = rank_rdata + IW'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          busy_d     = 1'b1;
          cmd_d      = cmd_i;
          key_d      = lookup_key_i;
          val_d      = write_value_i;
          ptr_d      = '0;
          found_d    = 1'b0;
          lru_any_d  = 1'b0;
          free_any_d = 1'b0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        chk_vld_d = 1'b1;
        ptr_d     = ptr_q + IW'(1);
        if (last) begin
          ptr_d   = '0;
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        hit_d     = found_q;
        rdval_d   = '0;
        evict_d   = 1'b0;
        age_all_d = 1'b0;
        ptr_d     = '0;
        state_d   = S_UPDATE;
        if (found_q) begin
          tgt_d = m_slot_q;
          thr_d = m_rank_q;
          if (cmd_q == CMD_SET) begin
            ent_we    = 1'b1;
            ent_waddr = m_slot_q;
          end else begin
            rdval_d = m_val_q;
          end
        end else if (cmd_q == CMD_GET) begin
          // get miss leaves the store untouched
          busy_d  = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (full) begin
          evict_d   = 1'b1;
          tgt_d     = lru_slot_q;
          thr_d     = lru_rank_q;
          ent_we    = 1'b1;
          ent_waddr = lru_slot_q;
        end else begin
          tgt_d                = free_slot_q;
          age_all_d            = 1'b1;
          ent_we               = 1'b1;
          ent_waddr            = free_slot_q;
          valid_d[free_slot_q] = 1'b1;
          count_d              = count_q + CW'(1);
        end
      end
      S_UPDATE: begin
        chk_vld_d = 1'b1;
        ptr_d     = ptr_q + IW'(1);
        if (last) begin
          ptr_d   = '0;
          state_d = S_UPD_END;
        end
      end
      S_UPD_END: begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      cap_q     <= CAP_RESET;
      valid_q   <= '0;
      count_q   <= '0;
      chk_vld_q <= 1'b0;
      ptr_q     <= '0;
    end else begin
      state_q   <= state_d;
      busy_q    <= busy_d;
      done_q    <= done_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
      ptr_q     <= ptr_d;
      if (capacity_we_i) begin
        cap_q <= capacity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q       <= hit_d;
    rdval_q     <= rdval_d;
    evict_q     <= evict_d;
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    val_q       <= val_d;
    chk_idx_q   <= chk_idx_d;
    found_q     <= found_d;
    m_slot_q    <= m_slot_d;
    m_rank_q    <= m_rank_d;
    m_val_q     <= m_val_d;
    lru_any_q   <= lru_any_d;
    lru_slot_q  <= lru_slot_d;
    lru_rank_q  <= lru_rank_d;
    free_any_q  <= free_any_d;
    free_slot_q <= free_slot_d;
    tgt_q       <= tgt_d;
    thr_q       <= thr_d;
    age_all_q   <= age_all_d;
  end

  assign busy         = busy_q;
  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign read_value_o = rdval_q;
  assign evicted_o    = evict_q;

  `LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `LKVC_ASSERT_NOW(a_done_after_busy, done_o, $past(busy) && !busy, "result without request")
  `LKVC_ASSERT_NOW(a_evict_is_miss, done_o && evicted_o, !hit_o, "eviction reported on a hit")
  `LKVC_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(ENTRIES), "entry count above depth")
  `LKVC_ASSERT_NOW(a_rank_rmw_sep, rank_we, rank_waddr != ptr_q, "rank write hits read address")

endmodule

`default_nettype wire

[sim/lru_key_value_cache_checker.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// watches the request, capacity and result ports of the lru key-value cache,
// keeps its own copy of the store and recency order, and compares every result
// field by field against the prediction made when its request was taken
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_tb_pkg;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } cache_cmd_e;

endpackage

module lru_key_value_cache_checker
  import lkvc_pkg::*;
  import lkvc_tb_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  busy_i,
  input  wire logic                  cmd_i,
  input  wire logic [KEY_BITS-1:0]   lookup_key_i,
  input  wire logic [VALUE_BITS-1:0] write_value_i,
  input  wire logic                  capacity_we_i,
  input  wire logic [CAP_BITS-1:0]   capacity_i,
  input  wire logic                  done_i,
  input  wire logic                  hit_i,
  input  wire logic [VALUE_BITS-1:0] read_value_i,
  input  wire logic                  evicted_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int RANK_BITS = $clog2(ENTRIES);

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
  } cache_result_t;

  logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
  logic [VALUE_BITS-1:0] slot_value [ENTRIES];
  logic                  slot_valid [ENTRIES];
  logic [RANK_BITS-1:0]  slot_rank  [ENTRIES];
  int                    live_count;
  logic [CAP_BITS-1:0]   capacity_q;
  cache_result_t         expected_results [$];
  int                    errors = 0;

  // out-of-range capacity is clamped to 1..ENTRIES
  function automatic int capacity_limit();
    if (capacity_q == '0) return 1;
    if (int'(capacity_q) > ENTRIES) return ENTRIES;
    return int'(capacity_q);
  endfunction

  // slot s becomes most recent, everything younger ages by one
  function automatic void make_most_recent(int s);
    logic [RANK_BITS-1:0] old_rank;
    old_rank = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
    end
    slot_rank[s] = '0;
  endfunction

  function automatic cache_result_t access_cache(cache_cmd_e op, logic [KEY_BITS-1:0] key,
                                                 logic [VALUE_BITS-1:0] val);
    cache_result_t        res;
    int                   slot;
    bit                   found;
    bit                   any;
    logic [RANK_BITS-1:0] oldest;
    res    = '0;
    slot   = 0;
    found  = 1'b0;
    any    = 1'b0;
    oldest = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && slot_valid[i] && slot_key[i] == key) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (op == CMD_GET) res.read_value = slot_value[slot];
      else slot_value[slot] = val;
      make_most_recent(slot);
    end else if (op == CMD_SET) begin
      if (live_count >= capacity_limit()) begin
        // reuse the least recent slot, first one wins on a tie
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && (!any || slot_rank[i] > oldest)) begin
            oldest = slot_rank[i];
            slot   = i;
            any    = 1'b1;
          end
        end
        res.evicted      = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = val;
        make_most_recent(slot);
      end else begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!slot_valid[i]) slot = i;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
        end
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = val;
        slot_rank[slot]  = '0;
        live_count++;
      end
    end
    return res;
  endfunction

  task automatic check_result(logic hit, logic [VALUE_BITS-1:0] read_value, logic evicted);
    cache_result_t exp;
    if (expected_results.size() == 0) begin
      $error("result with no request outstanding: hit %0d read_value %h evicted %0d",
             hit, read_value, evicted);
      errors++;
    end else begin
      exp = expected_results.pop_front();
      if (hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, hit);
        errors++;
      end
      if (read_value !== exp.read_value) begin
        $error("read_value: expected %h, got %h", exp.read_value, read_value);
        errors++;
      end
      if (evicted !== exp.evicted) begin
        $error("evicted: expected %0d, got %0d", exp.evicted, evicted);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i]  = '0;
      end
      live_count = 0;
      capacity_q = CAP_RESET;
      expected_results.delete();
    end else begin
      // retire first so a result never matches the request taken at the same edge
      if (done_i) check_result(hit_i, read_value_i, evicted_i);
      if (capacity_we_i) capacity_q = capacity_i;
      if (start_i && !busy_i) begin
        expected_results.push_back(access_cache(cache_cmd_e'(cmd_i), lookup_key_i,
                                                write_value_i));
      end
    end
    pending_o    <= expected_results.size();
    fail_count_o <= errors;
  end

endmodule

`default_nettype wire

[sim/tb_lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// drives get and set requests into the lru key-value cache: a short directed
// pass over empty, hit, update, eviction and clamped capacities, then random
// phases, small key pool per capacity setting, some with random request gaps
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_key_value_cache;
  import lkvc_pkg::*;
  import lkvc_tb_pkg::*;

  localparam int GAP_MAX       = 16;
  localparam int SETTLE_CYCLES = 2 * ENTRIES_DEF + 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 200;
  localparam int POOL_MAX      = 32;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      cmd_i = 1'b0;
  logic [KEY_BITS_DEF-1:0]   lookup_key_i = '0;
  logic [VALUE_BITS_DEF-1:0] write_value_i = '0;
  logic                      capacity_we_i = 1'b0;
  logic [CAP_BITS-1:0]       capacity_i = '0;
  logic                      busy;
  logic                      done_o;
  logic                      hit_o;
  logic [VALUE_BITS_DEF-1:0] read_value_o;
  logic                      evicted_o;
  int                        fail_count;
  int                        pending;

  bit                        gaps_on = 1'b1;
  logic [KEY_BITS_DEF-1:0]   key_pool [POOL_MAX];
  int                        pool_size = 1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  lru_key_value_cache uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .lookup_key_i (lookup_key_i),
    .write_value_i(write_value_i),
    .capacity_we_i(capacity_we_i),
    .capacity_i   (capacity_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o)
  );

  lru_key_value_cache_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd_i),
    .lookup_key_i (lookup_key_i),
    .write_value_i(write_value_i),
    .capacity_we_i(capacity_we_i),
    .capacity_i   (capacity_i),
    .done_i       (done_o),
    .hit_i        (hit_o),
    .read_value_i (read_value_o),
    .evicted_i    (evicted_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // start stays high until the request is taken; returns in the accepting step
  task automatic send_request(cache_cmd_e op, logic [KEY_BITS_DEF-1:0] key,
                              logic [VALUE_BITS_DEF-1:0] val);
    start         <= 1'b1;
    cmd_i         <= op;
    lookup_key_i  <= key;
    write_value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // gap counted either from the accept or from the block going idle again
  task automatic pace();
    int gap;
    bit from_idle;
    gap       = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    from_idle = $urandom_range(0, 1);
    if (gap > 0) begin
      start <= 1'b0;
      if (from_idle) begin
        @(posedge clk_i);
        while (busy) @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic request(cache_cmd_e op, logic [KEY_BITS_DEF-1:0] key,
                         logic [VALUE_BITS_DEF-1:0] val);
    send_request(op, key, val);
    pace();
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] cap);
    capacity_we_i <= 1'b1;
    capacity_i    <= cap;
    @(posedge clk_i);
    capacity_we_i <= 1'b0;
  endtask

  task automatic fill_pool(int n);
    pool_size = n;
    for (int i = 0; i < n; i++) key_pool[i] = $urandom();
  endtask

  task automatic random_request();
    cache_cmd_e              op;
    logic [KEY_BITS_DEF-1:0] key;
    op = ($urandom_range(0, 99) < 45) ? CMD_GET : CMD_SET;
    if ($urandom_range(0, 9) == 0) key = $urandom();
    else key = key_pool[$urandom_range(0, pool_size - 1)];
    request(op, key, $urandom());
  endtask

  initial begin : stimulus
    int cap_plan [8];
    int cap_eff;
    cap_plan = '{16, 1, 31, 0, 4, 0, 2, 0};
    cap_plan[5] = $urandom_range(0, 31);
    cap_plan[7] = $urandom_range(0, 31);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    request(CMD_GET, '0, '1);  // miss on an empty store
    request(CMD_SET, '0, '0);
    request(CMD_SET, '1, '1);
    request(CMD_GET, '1, '0);
    request(CMD_GET, '0, '0);
    request(CMD_SET, '0, 32'h5a5a_a5a5);  // update of a present key
    request(CMD_GET, '0, '0);
    request(CMD_SET, 32'h0000_0003, 32'h0000_0003);
    request(CMD_SET, 32'h8000_0004, 32'h0000_0004);
    request(CMD_GET, 32'h1234_5678, '0);
    wait_drain();
    write_capacity(5'd2);  // below the four entries already held
    request(CMD_SET, 32'h0000_0009, 32'h0000_0009);
    request(CMD_GET, '1, '0);
    request(CMD_GET, 32'h0000_0003, '0);
    request(CMD_SET, 32'h0000_000a, 32'h0000_000a);
    wait_drain();
    write_capacity('0);  // clamps to one
    request(CMD_SET, 32'h0000_000b, 32'h0000_000b);
    request(CMD_GET, 32'h0000_000b, '0);
    request(CMD_SET, 32'h0000_000c, 32'h0000_000c);
    request(CMD_GET, 32'h0000_000b, '0);
    wait_drain();
    write_capacity('1);  // clamps to the full store
    for (int i = 0; i < 5; i++) request(CMD_SET, 32'h0000_0100 + i, $urandom());

    foreach (cap_plan[p]) begin
      wait_drain();
      write_capacity(CAP_BITS'(cap_plan[p]));
      cap_eff = (cap_plan[p] == 0) ? 1 :
                (cap_plan[p] > ENTRIES_DEF) ? ENTRIES_DEF : cap_plan[p];
      fill_pool(cap_eff + $urandom_range(1, 8));
      gaps_on = (p % 3 != 1);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 63) == 0) wait_drain();
        random_request();
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("tb_lru_key_value_cache OK");
    else $display("tb_lru_key_value_cache NOT OK");
    $finish;
  end

  // any request or result taken restarts the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("tb_lru_key_value_cache NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
